@@ hdl/mfbf_pkg.sv @@
// Shared types and constants for the most frequent byte finder.
package mfbf_pkg;

   localparam int CHAR_W = 8;
   localparam int FPOS_W = 10;
   localparam int CNT_W  = 11;
   localparam int TABLE_DEPTH = 1 << CHAR_W;

   localparam logic [FPOS_W-1:0] FPOS_SAT = {FPOS_W{1'b1}};
   localparam logic [CNT_W-1:0]  CNT_SAT  = {CNT_W{1'b1}};

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [FPOS_W-1:0] fpos_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // One entry of the per-value table: occurrence count and first position.
   typedef struct packed {
      cnt_type  count;
      fpos_type first_pos;
   } entry_type;

endpackage

@@ hdl/most_frequent_byte_finder.sv @@
// Top level of the most frequent byte finder: histogram, leader tracking, result register.
//
// A string enters one byte per request on the req_ channel; req_last_char marks the
// final byte. A request is taken at a rising edge where req_valid is high and
// req_stall is low. Only the final byte produces a result on the rsp_ channel: the
// most frequent byte (ties go to the byte that appeared first), its zero-based first
// position, its count and an overflow flag for strings longer than MAX_LEN.
// Timing: one byte per cycle sustained while no final byte is held back by a stalled
// result, with no gap between strings. A final byte taken passes through the input
// register and the registered table read, then the count update writes the result
// register, where rsp_valid rises.
// Reset (synchronous, active high): clear the seen marks, position, leader, overflow
// flag and the valid bits. The count and position table is not cleared; the seen
// marks decide whether an entry is live, so no clearing pass is needed.
// Stall: a held result blocks only a final byte waiting in the input register; plain
// bytes keep flowing. The input stalls only while a final byte waits and the result
// register holds a stalled result.
module most_frequent_byte_finder #(
   parameter int MAX_LEN = 1024
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  mfbf_pkg::char_type  req_char_value,
   input  logic                req_last_char,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mfbf_pkg::char_type  rsp_mode_char,
   output mfbf_pkg::fpos_type  rsp_first_position,
   output mfbf_pkg::cnt_type   rsp_occurrences,
   output logic                rsp_overflow
);
   import mfbf_pkg::*;

   // Position counter must reach MAX_LEN itself.
   localparam int PosW  = $clog2(MAX_LEN + 1);
   localparam int WideW = PosW + FPOS_W + 1;

   // Per-value table: count and first position, one write and one read port.
   entry_type table_mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   // Seen marks, cleared at once at the end of every string.
   logic [TABLE_DEPTH-1:0] seen_ff, seen_in;

   // Input register.
   logic     s1_valid_ff;
   char_type s1_char_ff;
   logic     s1_last_ff;

   // Last table write, forwarded over a stale registered read.
   logic      fwd_valid_ff;
   char_type  fwd_char_ff;
   entry_type fwd_data_ff;

   // String state.
   logic [PosW-1:0] position_ff, position_in;
   char_type        leader_char_ff, leader_char_in;
   cnt_type         leader_count_ff, leader_count_in;
   fpos_type        leader_fpos_ff, leader_fpos_in;
   logic            overflow_ff, overflow_in;

   // Result register.
   logic     rsp_valid_ff;
   char_type rsp_char_ff;
   fpos_type rsp_fpos_ff;
   cnt_type  rsp_count_ff;
   logic     rsp_overflow_ff;

   logic            out_free;
   logic            advance;
   logic            accept;
   logic            full;
   logic            seen_hit;
   entry_type       old_entry;
   entry_type       new_entry;
   logic [WideW-1:0] pos_wide;
   logic            take_lead;
   logic            do_write;

   // Handshake: hold a final byte until the result register can take it.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Count update for the byte in the input register.
   always_comb begin
      full      = position_ff >= PosW'(MAX_LEN);
      seen_hit  = seen_ff[s1_char_ff];
      old_entry = (fwd_valid_ff && fwd_char_ff == s1_char_ff) ? fwd_data_ff : rd_data_ff;
      pos_wide  = WideW'(position_ff);
      if (seen_hit) begin
         new_entry.count     = (old_entry.count == CNT_SAT) ? CNT_SAT
                                                            : old_entry.count + 1'b1;
         new_entry.first_pos = old_entry.first_pos;
      end else begin
         new_entry.count     = cnt_type'(1);
         new_entry.first_pos = (pos_wide > WideW'(FPOS_SAT)) ? FPOS_SAT
                                                              : pos_wide[FPOS_W-1:0];
      end
      // Higher count wins; on a tie the earlier first appearance wins.
      take_lead = !full && ((new_entry.count > leader_count_ff) ||
                  (new_entry.count == leader_count_ff &&
                   new_entry.first_pos < leader_fpos_ff));
      do_write  = advance && !full;
   end

   // Next string state; the result takes the leader after this byte.
   always_comb begin
      seen_in         = seen_ff;
      position_in     = position_ff;
      leader_char_in  = leader_char_ff;
      leader_count_in = leader_count_ff;
      leader_fpos_in  = leader_fpos_ff;
      overflow_in     = overflow_ff;
      if (advance) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            seen_in[s1_char_ff] = 1'b1;
            position_in         = position_ff + 1'b1;
         end
         if (take_lead) begin
            leader_char_in  = s1_char_ff;
            leader_count_in = new_entry.count;
            leader_fpos_in  = new_entry.first_pos;
         end
      end
   end

   // Table memory: write the updated entry, read ahead for the request taken.
   always_ff @(posedge clock) begin
      if (do_write) begin
         table_mem[s1_char_ff] <= new_entry;
      end
      if (accept) begin
         rd_data_ff <= table_mem[req_char_value];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         seen_ff         <= '0;
         position_ff     <= '0;
         leader_char_ff  <= '0;
         leader_count_ff <= '0;
         leader_fpos_ff  <= '0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // Advance the input register.
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (do_write) begin
            fwd_valid_ff <= 1'b1;
         end
         // Drop all string state after the final byte.
         if (advance && s1_last_ff) begin
            seen_ff         <= '0;
            position_ff     <= '0;
            leader_char_ff  <= '0;
            leader_count_ff <= '0;
            leader_fpos_ff  <= '0;
            overflow_ff     <= 1'b0;
         end else begin
            seen_ff         <= seen_in;
            position_ff     <= position_in;
            leader_char_ff  <= leader_char_in;
            leader_count_ff <= leader_count_in;
            leader_fpos_ff  <= leader_fpos_in;
            overflow_ff     <= overflow_in;
         end
         if (out_free) begin
            rsp_valid_ff <= advance && s1_last_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_char_ff <= req_char_value;
         s1_last_ff <= req_last_char;
      end
      if (do_write) begin
         fwd_char_ff <= s1_char_ff;
         fwd_data_ff <= new_entry;
      end
      if (advance && s1_last_ff) begin
         rsp_char_ff     <= leader_char_in;
         rsp_fpos_ff     <= leader_fpos_in;
         rsp_count_ff    <= leader_count_in;
         rsp_overflow_ff <= overflow_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode_char      = rsp_char_ff;
   assign rsp_first_position = rsp_fpos_ff;
   assign rsp_occurrences    = rsp_count_ff;
   assign rsp_overflow       = rsp_overflow_ff;

   // Stall only with a byte waiting in the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff))
      else $error("input stalled without a pending final byte");

   // Every string has at least one counted byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occurrences != '0))
      else $error("result with zero occurrences");

   // String state returns to its reset value after a final byte.
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (position_ff == '0 && seen_ff == '0 &&
                                   leader_count_ff == '0 && !overflow_ff))
      else $error("string state not cleared after final byte");

   // The leader count never drops within a string.
   assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_last_ff) |=> (leader_count_ff >= $past(leader_count_ff)))
      else $error("leader count decreased");

endmodule

@@ tb/most_frequent_byte_finder_tb.sv @@
// Self-checking testbench for the most frequent byte finder: directed strings, then random ones.
`timescale 1ns / 1ps

module most_frequent_byte_finder_tb;
   import mfbf_pkg::*;

   localparam int STR_MAX_LEN  = 1024;
   localparam int RANDOM_ITEMS = 625;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_DIRECTED = 23;

   // Fields of one result, in port order.
   typedef struct packed {
      char_type mode_char;
      fpos_type first_position;
      cnt_type  occurrences;
      logic     overflow;
   } mode_result_type;

   // One directed request; want is only used where typed is set.
   typedef struct packed {
      char_type        ch;
      logic            last;
      logic            typed;
      mode_result_type want;
   } stim_row_type;

   localparam mode_result_type NO_RESULT = '0;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   char_type req_char_value;
   logic     req_last_char;
   logic     rsp_valid;
   logic     rsp_stall;
   char_type rsp_mode_char;
   fpos_type rsp_first_position;
   cnt_type  rsp_occurrences;
   logic     rsp_overflow;

   most_frequent_byte_finder #(
      .MAX_LEN(STR_MAX_LEN)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_value     (req_char_value),
      .req_last_char      (req_last_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mode_char      (rsp_mode_char),
      .rsp_first_position (rsp_first_position),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_overflow       (rsp_overflow)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Histogram predictor: own copy of the per-string state.
   // ------------------------------------------------------------------
   cnt_type  hist_count [TABLE_DEPTH];
   fpos_type hist_first [TABLE_DEPTH];
   bit       hist_seen  [TABLE_DEPTH];
   int       str_pos;
   char_type lead_char;
   cnt_type  lead_count;
   fpos_type lead_first;
   logic     str_overflow;

   mode_result_type expected_modes [$];

   int errors          = 0;
   int results_checked = 0;
   int overflow_seen   = 0;
   int bytes_sent      = 0;
   int strings_sent    = 0;
   int cur_len         = 0;
   int longest_string  = 0;
   int cycle_count     = 0;

   // Clear the per-string state; the count and position tables stay as they are.
   function automatic void clear_string_state();
      foreach (hist_seen[i]) hist_seen[i] = 1'b0;
      str_pos      = 0;
      lead_char    = '0;
      lead_count   = '0;
      lead_first   = '0;
      str_overflow = 1'b0;
   endfunction

   // Count one byte and update the leader; return 1 with the result on a final byte.
   function automatic bit tally_byte(input char_type c, input logic last,
                                     output mode_result_type res);
      cnt_type  n;
      fpos_type fp;
      res = NO_RESULT;
      if (str_pos >= STR_MAX_LEN) begin
         // Past the length limit: flag it, count nothing, hold the position.
         str_overflow = 1'b1;
      end else begin
         if (hist_seen[c]) begin
            n = hist_count[c];
            if (n != CNT_SAT) n = n + 1'b1;
            fp = hist_first[c];
         end else begin
            n  = cnt_type'(1);
            fp = (str_pos > int'(FPOS_SAT)) ? FPOS_SAT : fpos_type'(str_pos);
            hist_seen[c]  = 1'b1;
            hist_first[c] = fp;
         end
         hist_count[c] = n;
         str_pos++;
         // Higher count wins; equal count goes to the earlier first position.
         if (n > lead_count || (n == lead_count && fp < lead_first)) begin
            lead_char  = c;
            lead_count = n;
            lead_first = fp;
         end
      end
      if (!last) return 1'b0;
      res = '{lead_char, lead_first, lead_count, str_overflow};
      clear_string_state();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Request side: drive at the falling edge, detect acceptance at the rising edge.
   // ------------------------------------------------------------------
   int burst_left = 0;

   // Drive one byte, hold it until taken, then log what it should produce.
   task automatic send_byte(input char_type c, input logic last, input logic typed,
                            input mode_result_type typed_want);
      mode_result_type res;
      bit              has_res;
      req_valid      <= 1'b1;
      req_char_value <= c;
      req_last_char  <= last;
      do @(posedge clock); while (req_stall);
      has_res = tally_byte(c, last, res);
      if (has_res) expected_modes.push_back(typed ? typed_want : res);
      bytes_sent++;
      cur_len++;
      if (last) begin
         strings_sent++;
         if (cur_len > longest_string) longest_string = cur_len;
         cur_len = 0;
      end
      @(negedge clock);
   endtask

   // Work in bursts: at the end of a burst drop valid, then start a burst of random length.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      gap = $urandom_range(1, 6);
      // Mostly short bursts, now and then a long back-to-back stretch.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   // Hold the sender until every expected result has left the block.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_modes.size() != 0) @(negedge clock);
   endtask

   // One random string of the given length; a narrow alphabet forces repeats and ties.
   task automatic send_random_string(input int len);
      char_type base;
      int       span;
      bit       narrow;
      narrow = ($urandom_range(0, 2) != 0);
      base   = char_type'($urandom_range(0, 255));
      span   = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) begin
         send_byte(narrow ? char_type'(base + $urandom_range(0, span))
                          : char_type'($urandom_range(0, 255)),
                   i == len - 1, 1'b0, NO_RESULT);
         pace_sender();
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: stall on a pattern that changes style every so often.
   // ------------------------------------------------------------------
   int   stall_style = 0;
   int   stall_span  = 0;
   int   run_left    = 0;
   logic run_state   = 1'b0;

   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_span  = $urandom_range(30, 150);
      end
      stall_span--;
      case (stall_style)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         2: begin
            // Alternate runs of stall and release.
            if (run_left == 0) begin
               run_state = ~run_state;
               run_left  = $urandom_range(1, 12);
            end
            run_left--;
            rsp_stall <= run_state;
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
      endcase
   end

   // Compare one field and report a mismatch.
   task automatic check_field(input string field, input int want, input int seen);
      if (want != seen) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                  $time, field, want, want, seen, seen);
      end
   endtask

   // Check every accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin : check_rsp
         mode_result_type want;
         if (expected_modes.size() == 0) begin
            errors++;
            $display({"%0t ns: result with nothing expected, ",
                      "actual char 0x%0h pos %0d cnt %0d ovf %0d"},
                     $time, rsp_mode_char, rsp_first_position, rsp_occurrences,
                     rsp_overflow);
         end else begin
            want = expected_modes.pop_front();
            check_field("mode_char",      want.mode_char,      rsp_mode_char);
            check_field("first_position", want.first_position, rsp_first_position);
            check_field("occurrences",    want.occurrences,    rsp_occurrences);
            check_field("overflow",       want.overflow,       rsp_overflow);
            results_checked++;
            if (rsp_overflow) overflow_seen++;
         end
      end
   end

   // Bound the run in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_modes.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------
   stim_row_type directed_rows [NUM_DIRECTED];

   initial begin
      int random_items;
      int string_idx;
      int len;

      // Single bytes: extremes of the byte value, zero included.
      directed_rows[0]  = '{8'h41, 1'b1, 1'b1, '{8'h41, 10'd0, 11'd1, 1'b0}};
      directed_rows[1]  = '{8'h00, 1'b1, 1'b1, '{8'h00, 10'd0, 11'd1, 1'b0}};
      directed_rows[2]  = '{8'hFF, 1'b1, 1'b1, '{8'hFF, 10'd0, 11'd1, 1'b0}};
      // Tie on count: the value that appeared first wins.
      directed_rows[3]  = '{8'h78, 1'b0, 1'b0, NO_RESULT};
      directed_rows[4]  = '{8'h79, 1'b0, 1'b0, NO_RESULT};
      directed_rows[5]  = '{8'h79, 1'b0, 1'b0, NO_RESULT};
      directed_rows[6]  = '{8'h78, 1'b1, 1'b1, '{8'h78, 10'd0, 11'd2, 1'b0}};
      // A later value overtakes the first one.
      directed_rows[7]  = '{8'h61, 1'b0, 1'b0, NO_RESULT};
      directed_rows[8]  = '{8'h62, 1'b0, 1'b0, NO_RESULT};
      directed_rows[9]  = '{8'h62, 1'b0, 1'b0, NO_RESULT};
      directed_rows[10] = '{8'h62, 1'b1, 1'b1, '{8'h62, 10'd1, 11'd3, 1'b0}};
      // Alternating bit patterns.
      directed_rows[11] = '{8'hAA, 1'b0, 1'b0, NO_RESULT};
      directed_rows[12] = '{8'h55, 1'b0, 1'b0, NO_RESULT};
      directed_rows[13] = '{8'h55, 1'b0, 1'b0, NO_RESULT};
      directed_rows[14] = '{8'hAA, 1'b0, 1'b0, NO_RESULT};
      directed_rows[15] = '{8'h55, 1'b1, 1'b1, '{8'h55, 10'd1, 11'd3, 1'b0}};
      // Zero and all-ones tie; zero came first.
      directed_rows[16] = '{8'h00, 1'b0, 1'b0, NO_RESULT};
      directed_rows[17] = '{8'hFF, 1'b0, 1'b0, NO_RESULT};
      directed_rows[18] = '{8'hFF, 1'b0, 1'b0, NO_RESULT};
      directed_rows[19] = '{8'h00, 1'b1, 1'b1, '{8'h00, 10'd0, 11'd2, 1'b0}};
      // Left to the predictor.
      directed_rows[20] = '{8'h01, 1'b0, 1'b0, NO_RESULT};
      directed_rows[21] = '{8'h80, 1'b0, 1'b0, NO_RESULT};
      directed_rows[22] = '{8'h80, 1'b1, 1'b0, NO_RESULT};

      // Drive the request inputs from time zero while reset is held.
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_char_value = '0;
      req_last_char  = 1'b0;
      clear_string_state();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed rows.
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].ch, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);
         pace_sender();
      end

      // Random strings, mostly short with a few longer ones mixed in.
      random_items = 0;
      string_idx   = 0;
      while (random_items < RANDOM_ITEMS) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                           : $urandom_range(1, 16);
         send_random_string(len);
         random_items += len;
         // Pause now and then until the block has nothing in flight.
         if (string_idx == 10 || $urandom_range(0, 14) == 0) hold_until_drained();
         string_idx++;
      end

      // Drain, then let the pipeline settle.
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d strings (%0d bytes, longest %0d); checked %0d results, %0d overflowed.",
               strings_sent, bytes_sent, longest_string, results_checked, overflow_seen);
      if (errors == 0 && expected_modes.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
